// File: hdl/rcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types, widths and constants of the raycast column texel mapper.
// ----------------------------------------------------------------------------
package rcm_pkg;

    // Screen and texture geometry (textures are a power of two on each side)
    localparam int SCREEN_HEIGHT  = 512;
    localparam int TEXTURE_WIDTH  = 64;
    localparam int TEXTURE_HEIGHT = 64;
    localparam int TEX_W_BITS     = $clog2(TEXTURE_WIDTH);
    localparam int TEX_H_BITS     = $clog2(TEXTURE_HEIGHT);

    // Field widths
    localparam int COLUMN_W = 10;
    localparam int ROW_W    = 9;
    localparam int POS_W    = 24;
    localparam int RAY_W    = 18;
    localparam int DIST_W   = 24;
    localparam int HEIGHT_W = 16;
    localparam int TEXEL_W  = 6;
    localparam int COLOR_W  = 32;
    localparam int PITCH_W  = 10;

    // Product of distance and ray component; texel x is the top of its low word
    localparam int PROD_W   = DIST_W + 1 + RAY_W;
    localparam int FRAC_MSB = 31;

    // Row offset n and its magnitude
    localparam int N_W   = 18;
    localparam int MAG_W = N_W - 1;

    // Restoring divider: magnitude times texture height over slice height
    localparam int REM_W      = HEIGHT_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_BITS   = MAG_W + TEX_H_BITS;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_DW     = DIV_STAGES * DIV_STEPS;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PITCH    = 2'd2;

    localparam logic signed [PITCH_W-1:0] PITCH_RESET = 10'sd100;

    typedef enum logic [1:0] {
        KIND_CEILING = 2'd0,
        KIND_WALL    = 2'd1,
        KIND_FLOOR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FACE_NORTH = 2'd0,
        FACE_SOUTH = 2'd1,
        FACE_WEST  = 2'd2,
        FACE_EAST  = 2'd3
    } face_t;

    // Per-pixel data that rides alongside the divider
    typedef struct packed {
        kind_t                 kind;
        face_t                 face;
        logic [TEX_W_BITS-1:0] tx;
        logic                  neg;
        logic                  zero_h;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_W-1:0]      row;
    } side_t;

    // Divider working set: partial remainder, divisor, dividend/quotient shift
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [HEIGHT_W-1:0] divisor;
        logic [DIV_DW-1:0]   dq;
    } div_t;

endpackage : rcm_pkg
`default_nettype wire

// File: hdl/rcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_front
// First stage: classify the row, pick the face, form texel x from the hit
// fraction and prepare the texel y division.
// ----------------------------------------------------------------------------
module rcm_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [rcm_pkg::COLUMN_W-1:0]        column,
    input  wire logic [rcm_pkg::ROW_W-1:0]           row,
    input  wire logic signed [rcm_pkg::RAY_W-1:0]    ray_x,
    input  wire logic signed [rcm_pkg::RAY_W-1:0]    ray_y,
    input  wire logic [rcm_pkg::DIST_W-1:0]          wall_distance,
    input  wire logic                                hit_side,
    input  wire logic [rcm_pkg::HEIGHT_W-1:0]        slice_height,
    input  wire logic [rcm_pkg::ROW_W-1:0]           slice_top,
    input  wire logic [rcm_pkg::ROW_W-1:0]           slice_end,
    input  wire logic signed [rcm_pkg::PITCH_W-1:0]  view_pitch,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output rcm_pkg::side_t                           out_side,
    output rcm_pkg::div_t                            out_div
);

    logic                                   valid_reg;
    rcm_pkg::side_t                         side_reg;
    rcm_pkg::side_t                         side_next;
    rcm_pkg::div_t                          div_reg;
    rcm_pkg::div_t                          div_next;

    logic signed [rcm_pkg::RAY_W-1:0]       ray_sel;
    logic signed [rcm_pkg::PROD_W-1:0]      prod;
    logic                                   rx_pos;
    logic                                   ry_pos;
    logic                                   ry_neg;
    logic                                   mirror;
    logic signed [rcm_pkg::N_W-1:0]         n;
    logic [rcm_pkg::N_W-1:0]                n_abs;

    always_comb begin
        ray_sel = hit_side ? ray_x : ray_y;
        prod    = $signed({1'b0, wall_distance}) * ray_sel;

        rx_pos = !ray_x[rcm_pkg::RAY_W-1] && (ray_x != '0);
        ry_pos = !ray_y[rcm_pkg::RAY_W-1] && (ray_y != '0);
        ry_neg = ray_y[rcm_pkg::RAY_W-1];
        mirror = hit_side ? ry_neg : rx_pos;

        n = rcm_pkg::N_W'($signed({1'b0, row}))
          - rcm_pkg::N_W'(view_pitch)
          - rcm_pkg::N_W'(rcm_pkg::SCREEN_HEIGHT / 2)
          + rcm_pkg::N_W'($signed({1'b0, slice_height[rcm_pkg::HEIGHT_W-1:1]}));
        n_abs = n[rcm_pkg::N_W-1] ? rcm_pkg::N_W'(-n) : rcm_pkg::N_W'(n);

        side_next.column = column;
        side_next.row    = row;
        if (row < slice_top) begin
            side_next.kind = rcm_pkg::KIND_CEILING;
        end else if (row >= slice_end) begin
            side_next.kind = rcm_pkg::KIND_FLOOR;
        end else begin
            side_next.kind = rcm_pkg::KIND_WALL;
        end
        if (hit_side) begin
            side_next.face = ry_pos ? rcm_pkg::FACE_SOUTH : rcm_pkg::FACE_NORTH;
        end else begin
            side_next.face = rx_pos ? rcm_pkg::FACE_EAST : rcm_pkg::FACE_WEST;
        end
        // Mirror within the texture: W-1-x is the bitwise complement
        side_next.tx = prod[rcm_pkg::FRAC_MSB -: rcm_pkg::TEX_W_BITS]
                     ^ {rcm_pkg::TEX_W_BITS{mirror}};
        side_next.neg    = n[rcm_pkg::N_W-1];
        side_next.zero_h = (slice_height == '0);

        div_next.rem     = '0;
        div_next.divisor = slice_height;
        div_next.dq      = rcm_pkg::DIV_DW'({n_abs[rcm_pkg::MAG_W-1:0],
                                             {rcm_pkg::TEX_H_BITS{1'b0}}});
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule : rcm_front
`default_nettype wire

// File: hdl/rcm_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcm_div_stage
// One register stage of the restoring divider: DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module rcm_div_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rcm_pkg::side_t  in_side,
    input  wire rcm_pkg::div_t   in_div,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rcm_pkg::side_t       out_side,
    output rcm_pkg::div_t        out_div
);

    logic                        valid_reg;
    rcm_pkg::side_t              side_reg;
    rcm_pkg::div_t               div_reg;
    rcm_pkg::div_t               div_next;
    logic [rcm_pkg::REM_W:0]     trial;
    logic                        qbit;

    always_comb begin
        div_next = in_div;
        trial    = '0;
        qbit     = 1'b0;
        for (int k = 0; k < rcm_pkg::DIV_STEPS; k++) begin
            trial = {div_next.rem, div_next.dq[rcm_pkg::DIV_DW-1]};
            qbit  = (trial >= {1'b0, div_next.divisor});
            if (qbit) begin
                div_next.rem = rcm_pkg::REM_W'(trial - {1'b0, div_next.divisor});
            end else begin
                div_next.rem = trial[rcm_pkg::REM_W-1:0];
            end
            div_next.dq = {div_next.dq[rcm_pkg::DIV_DW-2:0], qbit};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule : rcm_div_stage
`default_nettype wire

// File: hdl/raycast_column_texel_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_column_texel_mapper
// Per-pixel ceiling/wall/floor classification and wall texel coordinates.
// ----------------------------------------------------------------------------
// Takes one screen pixel per request together with the ray hit data of its
// column and returns one result per request, in order. Throughput is one
// pixel per clock while results are taken; texel y comes from the pipelined
// restoring divider at two quotient bits per stage. Every stage carries its
// own valid bit and takes a new request whenever it is empty or its
// successor moves, so bubbles are squeezed out and a held result does not
// block fresh requests until the pipeline is full. Configuration (ceiling
// color, floor color, view pitch) is written through the cfg_ port, which is
// always ready; write it only while no pixel is in flight. Writes to an
// unused index are dropped.
// ----------------------------------------------------------------------------
module raycast_column_texel_mapper (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rcm_pkg::COLOR_W-1:0]         cfg_data,

    // Pixel request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rcm_pkg::COLUMN_W-1:0]        s_column,
    input  wire logic [rcm_pkg::ROW_W-1:0]           s_row,
    input  wire logic [rcm_pkg::POS_W-1:0]           s_player_x,
    input  wire logic [rcm_pkg::POS_W-1:0]           s_player_y,
    input  wire logic signed [rcm_pkg::RAY_W-1:0]    s_ray_x,
    input  wire logic signed [rcm_pkg::RAY_W-1:0]    s_ray_y,
    input  wire logic [rcm_pkg::DIST_W-1:0]          s_wall_distance,
    input  wire logic                                s_hit_side,
    input  wire logic [rcm_pkg::HEIGHT_W-1:0]        s_slice_height,
    input  wire logic [rcm_pkg::ROW_W-1:0]           s_slice_top,
    input  wire logic [rcm_pkg::ROW_W-1:0]           s_slice_end,

    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rcm_pkg::COLUMN_W-1:0]             m_out_column,
    output logic [rcm_pkg::ROW_W-1:0]                m_out_row,
    output logic [1:0]                               m_pixel_kind,
    output logic [1:0]                               m_wall_face,
    output logic [rcm_pkg::TEXEL_W-1:0]              m_texel_x,
    output logic [rcm_pkg::TEXEL_W-1:0]              m_texel_y,
    output logic [rcm_pkg::COLOR_W-1:0]              m_fill_color
);

    // Configuration registers
    logic [rcm_pkg::COLOR_W-1:0]         ceiling_color_reg;
    logic [rcm_pkg::COLOR_W-1:0]         floor_color_reg;
    logic signed [rcm_pkg::PITCH_W-1:0]  view_pitch_reg;

    // Pipeline links: index 0 is the front stage, the rest are divider stages
    logic                                pipe_valid [0:rcm_pkg::DIV_STAGES];
    logic                                pipe_ready [0:rcm_pkg::DIV_STAGES];
    rcm_pkg::side_t                      pipe_side  [0:rcm_pkg::DIV_STAGES];
    rcm_pkg::div_t                       pipe_div   [0:rcm_pkg::DIV_STAGES];

    // Output register
    logic                                m_valid_reg;
    logic                                out_ready;
    logic [rcm_pkg::COLUMN_W-1:0]        column_reg;
    logic [rcm_pkg::ROW_W-1:0]           row_reg;
    rcm_pkg::kind_t                      kind_reg;
    rcm_pkg::kind_t                      kind_next;
    rcm_pkg::face_t                      face_reg;
    rcm_pkg::face_t                      face_next;
    logic [rcm_pkg::TEXEL_W-1:0]         texel_x_reg;
    logic [rcm_pkg::TEXEL_W-1:0]         texel_x_next;
    logic [rcm_pkg::TEXEL_W-1:0]         texel_y_reg;
    logic [rcm_pkg::TEXEL_W-1:0]         texel_y_next;
    logic [rcm_pkg::COLOR_W-1:0]         color_reg;
    logic [rcm_pkg::COLOR_W-1:0]         color_next;
    logic [rcm_pkg::TEX_H_BITS-1:0]      quot_low;
    logic [rcm_pkg::TEX_H_BITS-1:0]      ty_wrapped;
    rcm_pkg::side_t                      last_side;

    // ------------------------------------------------------------------------
    // Configuration: always ready, unknown indexes are dropped
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_color_reg <= '0;
            floor_color_reg   <= '0;
            view_pitch_reg    <= rcm_pkg::PITCH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rcm_pkg::CFG_CEILING_COLOR: ceiling_color_reg <= cfg_data;
                rcm_pkg::CFG_FLOOR_COLOR:   floor_color_reg   <= cfg_data;
                rcm_pkg::CFG_VIEW_PITCH:
                    view_pitch_reg <= cfg_data[rcm_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Front stage: classification, face, texel x, division setup. The player
    // position only shifts the hit coordinate by whole map units, so its
    // fraction (and texel x) comes from the distance-times-ray product alone.
    // ------------------------------------------------------------------------
    rcm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .column        (s_column),
        .row           (s_row),
        .ray_x         (s_ray_x),
        .ray_y         (s_ray_y),
        .wall_distance (s_wall_distance),
        .hit_side      (s_hit_side),
        .slice_height  (s_slice_height),
        .slice_top     (s_slice_top),
        .slice_end     (s_slice_end),
        .view_pitch    (view_pitch_reg),
        .out_valid     (pipe_valid[0]),
        .out_ready     (pipe_ready[0]),
        .out_side      (pipe_side[0]),
        .out_div       (pipe_div[0])
    );

    // ------------------------------------------------------------------------
    // Divider chain: |n| * TEXTURE_HEIGHT / slice_height
    // ------------------------------------------------------------------------
    for (genvar g = 1; g <= rcm_pkg::DIV_STAGES; g++) begin : g_div
        rcm_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[g-1]),
            .in_ready  (pipe_ready[g-1]),
            .in_side   (pipe_side[g-1]),
            .in_div    (pipe_div[g-1]),
            .out_valid (pipe_valid[g]),
            .out_ready (pipe_ready[g]),
            .out_side  (pipe_side[g]),
            .out_div   (pipe_div[g])
        );
    end

    assign out_ready                         = !m_valid_reg || m_ready;
    assign pipe_ready[rcm_pkg::DIV_STAGES]   = out_ready;
    assign last_side                         = pipe_side[rcm_pkg::DIV_STAGES];

    // ------------------------------------------------------------------------
    // Output formatting: apply the sign of n to the quotient (truncation
    // toward zero), wrap to the texture height, zero fields by pixel kind.
    // ------------------------------------------------------------------------
    always_comb begin
        quot_low   = pipe_div[rcm_pkg::DIV_STAGES].dq[rcm_pkg::TEX_H_BITS-1:0];
        ty_wrapped = last_side.neg ? rcm_pkg::TEX_H_BITS'(-quot_low) : quot_low;
        kind_next  = last_side.kind;

        face_next    = rcm_pkg::FACE_NORTH;
        texel_x_next = '0;
        texel_y_next = '0;
        color_next   = '0;
        case (last_side.kind)
            rcm_pkg::KIND_CEILING: color_next = ceiling_color_reg;
            rcm_pkg::KIND_FLOOR:   color_next = floor_color_reg;
            rcm_pkg::KIND_WALL: begin
                face_next    = last_side.face;
                texel_x_next = rcm_pkg::TEXEL_W'(last_side.tx);
                // Zero slice height: the quotient is ignored, texel row 0
                if (!last_side.zero_h) begin
                    texel_y_next = rcm_pkg::TEXEL_W'(ty_wrapped);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= pipe_valid[rcm_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && pipe_valid[rcm_pkg::DIV_STAGES]) begin
            column_reg  <= last_side.column;
            row_reg     <= last_side.row;
            kind_reg    <= kind_next;
            face_reg    <= face_next;
            texel_x_reg <= texel_x_next;
            texel_y_reg <= texel_y_next;
            color_reg   <= color_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_column = column_reg;
    assign m_out_row    = row_reg;
    assign m_pixel_kind = kind_reg;
    assign m_wall_face  = face_reg;
    assign m_texel_x    = texel_x_reg;
    assign m_texel_y    = texel_y_reg;
    assign m_fill_color = color_reg;

endmodule : raycast_column_texel_mapper
`default_nettype wire

// File: verif/rcm_texel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_texel_checker
// Predicts each pixel's class, face, texel and fill color and checks results.
// ----------------------------------------------------------------------------
// Watches the configuration, request and result channels of the raycast
// column texel mapper. Keeps its own copy of the registers, queues one
// predicted texel per accepted request and compares every accepted result,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module rcm_texel_checker
    import rcm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COLOR_W-1:0]         cfg_data,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [COLUMN_W-1:0]        s_column,
    input  logic [ROW_W-1:0]           s_row,
    input  logic [POS_W-1:0]           s_player_x,
    input  logic [POS_W-1:0]           s_player_y,
    input  logic signed [RAY_W-1:0]    s_ray_x,
    input  logic signed [RAY_W-1:0]    s_ray_y,
    input  logic [DIST_W-1:0]          s_wall_distance,
    input  logic                       s_hit_side,
    input  logic [HEIGHT_W-1:0]        s_slice_height,
    input  logic [ROW_W-1:0]           s_slice_top,
    input  logic [ROW_W-1:0]           s_slice_end,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [COLUMN_W-1:0]        m_out_column,
    input  logic [ROW_W-1:0]           m_out_row,
    input  logic [1:0]                 m_pixel_kind,
    input  logic [1:0]                 m_wall_face,
    input  logic [TEXEL_W-1:0]         m_texel_x,
    input  logic [TEXEL_W-1:0]         m_texel_y,
    input  logic [COLOR_W-1:0]         m_fill_color,

    output int                         mismatch_count,
    output int                         pending,
    output int                         ceiling_seen,
    output int                         wall_seen,
    output int                         floor_seen
);

    typedef struct {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        kind_t               kind;
        face_t               face;
        logic [TEXEL_W-1:0]  tx;
        logic [TEXEL_W-1:0]  ty;
        logic [COLOR_W-1:0]  color;
    } texel_t;

    logic [COLOR_W-1:0]        cfg_ceiling;
    logic [COLOR_W-1:0]        cfg_floor;
    logic signed [PITCH_W-1:0] cfg_pitch;

    texel_t expected_texels[$];

    initial begin
        mismatch_count = 0;
        pending        = 0;
        ceiling_seen   = 0;
        wall_seen      = 0;
        floor_seen     = 0;
    end

    function automatic texel_t predict_texel(
        input logic [COLUMN_W-1:0]     column,
        input logic [ROW_W-1:0]        row,
        input logic [POS_W-1:0]        player_x,
        input logic [POS_W-1:0]        player_y,
        input logic signed [RAY_W-1:0] ray_x,
        input logic signed [RAY_W-1:0] ray_y,
        input logic [DIST_W-1:0]       distance,
        input logic                    hit_side,
        input logic [HEIGHT_W-1:0]     slice_height,
        input logic [ROW_W-1:0]        slice_top,
        input logic [ROW_W-1:0]        slice_end
    );
        texel_t      r;
        logic [63:0] prod;
        longint      n;
        longint      num;
        longint      mag;
        longint      q;
        r.column = column;
        r.row    = row;
        r.kind   = KIND_WALL;
        r.face   = FACE_NORTH;
        r.tx     = '0;
        r.ty     = '0;
        r.color  = '0;
        if (row < slice_top) begin
            r.kind  = KIND_CEILING;
            r.color = cfg_ceiling;
        end else if (row >= slice_end) begin
            r.kind  = KIND_FLOOR;
            r.color = cfg_floor;
        end else begin
            // The player position only touches the integer part of the hit,
            // so the fraction comes from the distance times ray product alone.
            if (!hit_side) begin
                r.face = (ray_x > 0) ? FACE_EAST : FACE_WEST;
                prod   = longint'(distance) * longint'(ray_y);
            end else begin
                r.face = (ray_y > 0) ? FACE_SOUTH : FACE_NORTH;
                prod   = longint'(distance) * longint'(ray_x);
            end
            r.tx = prod[31 -: TEX_W_BITS];
            if ((!hit_side && ray_x > 0) || (hit_side && ray_y < 0))
                r.tx = TEXEL_W'(TEXTURE_WIDTH - 1) - r.tx;
            if (slice_height != 0) begin
                n   = longint'(row) - longint'(cfg_pitch) - SCREEN_HEIGHT / 2
                      + longint'(slice_height / 2);
                num = n * TEXTURE_HEIGHT;
                mag = (num < 0) ? -num : num;
                q   = mag / longint'(slice_height);
                if (num < 0)
                    q = -q;
                r.ty = TEXEL_W'(q);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : scoreboard
        texel_t want;
        if (!aresetn) begin
            cfg_ceiling = '0;
            cfg_floor   = '0;
            cfg_pitch   = PITCH_RESET;
            expected_texels.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CEILING_COLOR: cfg_ceiling = cfg_data;
                    CFG_FLOOR_COLOR:   cfg_floor   = cfg_data;
                    CFG_VIEW_PITCH:    cfg_pitch   = cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                expected_texels.push_back(predict_texel(
                    s_column, s_row, s_player_x, s_player_y, s_ray_x, s_ray_y,
                    s_wall_distance, s_hit_side, s_slice_height, s_slice_top,
                    s_slice_end));

            if (m_valid && m_ready) begin
                if (expected_texels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result for pixel (%0d,%0d)",
                                 $time, m_out_column, m_out_row);
                end else begin
                    want = expected_texels.pop_front();
                    case (want.kind)
                        KIND_CEILING: ceiling_seen++;
                        KIND_WALL:    wall_seen++;
                        default:      floor_seen++;
                    endcase
                    if (m_out_column !== want.column || m_out_row !== want.row ||
                        m_pixel_kind !== want.kind || m_wall_face !== want.face ||
                        m_texel_x !== want.tx || m_texel_y !== want.ty ||
                        m_fill_color !== want.color) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected col %0d row %0d kind %0d face %0d tx %0d ty %0d color %h",
                                     $time, want.column, want.row, want.kind, want.face,
                                     want.tx, want.ty, want.color);
                            $display("%0t:   actual col %0d row %0d kind %0d face %0d tx %0d ty %0d color %h",
                                     $time, m_out_column, m_out_row, m_pixel_kind,
                                     m_wall_face, m_texel_x, m_texel_y, m_fill_color);
                        end
                    end
                end
            end
            pending <= expected_texels.size();
        end
    end

endmodule : rcm_texel_checker

// File: verif/tb_raycast_column_texel_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raycast_column_texel_mapper
// Stimulus and verdict for the raycast column texel mapper.
// ----------------------------------------------------------------------------
// Drives pixel requests and register writes, throttles the result side, and
// leaves prediction and comparison to rcm_texel_checker. A directed set hits
// every pixel class, every wall face, the mirrored texel cases, zero slice
// height, inverted slice bounds and the field extremes; then five random
// phases run under different register settings, one of them with no sender
// gaps while the result side holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_raycast_column_texel_mapper;
    import rcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLD_AFTER   = 300;   // results taken before the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;    // settling wait after the checker queue empties
    localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all

    typedef struct {
        logic [COLUMN_W-1:0]     column;
        logic [ROW_W-1:0]        row;
        logic [POS_W-1:0]        player_x;
        logic [POS_W-1:0]        player_y;
        logic signed [RAY_W-1:0] ray_x;
        logic signed [RAY_W-1:0] ray_y;
        logic [DIST_W-1:0]       distance;
        logic                    hit_side;
        logic [HEIGHT_W-1:0]     slice_height;
        logic [ROW_W-1:0]        slice_top;
        logic [ROW_W-1:0]        slice_end;
    } pixel_req_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [COLOR_W-1:0]      cfg_data  = '0;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [COLUMN_W-1:0]     s_column        = '0;
    logic [ROW_W-1:0]        s_row           = '0;
    logic [POS_W-1:0]        s_player_x      = '0;
    logic [POS_W-1:0]        s_player_y      = '0;
    logic signed [RAY_W-1:0] s_ray_x         = '0;
    logic signed [RAY_W-1:0] s_ray_y         = '0;
    logic [DIST_W-1:0]       s_wall_distance = '0;
    logic                    s_hit_side      = 1'b0;
    logic [HEIGHT_W-1:0]     s_slice_height  = '0;
    logic [ROW_W-1:0]        s_slice_top     = '0;
    logic [ROW_W-1:0]        s_slice_end     = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [COLUMN_W-1:0]     m_out_column;
    logic [ROW_W-1:0]        m_out_row;
    logic [1:0]              m_pixel_kind;
    logic [1:0]              m_wall_face;
    logic [TEXEL_W-1:0]      m_texel_x;
    logic [TEXEL_W-1:0]      m_texel_y;
    logic [COLOR_W-1:0]      m_fill_color;

    int mismatch_count;
    int pending;
    int ceiling_seen;
    int wall_seen;
    int floor_seen;
    int settings_applied = 0;
    int idle_cycles = 0;

    raycast_column_texel_mapper dut (.*);

    rcm_texel_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic pixel_req_t make_pixel(
        input logic [COLUMN_W-1:0]     column,
        input logic [ROW_W-1:0]        row,
        input logic [POS_W-1:0]        player_x,
        input logic [POS_W-1:0]        player_y,
        input logic signed [RAY_W-1:0] ray_x,
        input logic signed [RAY_W-1:0] ray_y,
        input logic [DIST_W-1:0]       distance,
        input logic                    hit_side,
        input logic [HEIGHT_W-1:0]     slice_height,
        input logic [ROW_W-1:0]        slice_top,
        input logic [ROW_W-1:0]        slice_end
    );
        pixel_req_t p;
        p.column       = column;
        p.row          = row;
        p.player_x     = player_x;
        p.player_y     = player_y;
        p.ray_x        = ray_x;
        p.ray_y        = ray_y;
        p.distance     = distance;
        p.hit_side     = hit_side;
        p.slice_height = slice_height;
        p.slice_top    = slice_top;
        p.slice_end    = slice_end;
        return p;
    endfunction

    // Favor zero and the two extremes; the sign of a ray picks face and mirror.
    function automatic logic signed [RAY_W-1:0] random_ray();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return 18'sh20000;
            2:       return 18'sh1FFFF;
            default: return RAY_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed slices with the row inside the wall band, since
    // that is where all the texel arithmetic lives; the rest is noise.
    function automatic pixel_req_t random_pixel();
        pixel_req_t p;
        int         pick;
        p.column   = COLUMN_W'($urandom);
        p.player_x = POS_W'($urandom);
        p.player_y = POS_W'($urandom);
        p.ray_x    = random_ray();
        p.ray_y    = random_ray();
        p.hit_side = 1'($urandom);

        pick = $urandom_range(0, 9);
        if (pick == 0)
            p.distance = '0;
        else if (pick == 1)
            p.distance = '1;
        else
            p.distance = DIST_W'($urandom);

        pick = $urandom_range(0, 19);
        if (pick == 0)
            p.slice_height = '0;
        else if (pick == 1)
            p.slice_height = '1;
        else if (pick < 5)
            p.slice_height = HEIGHT_W'($urandom_range(1, 65535));
        else
            p.slice_height = HEIGHT_W'($urandom_range(1, 1024));

        if ($urandom_range(0, 9) == 0) begin
            p.slice_top = ROW_W'($urandom);
            p.slice_end = ROW_W'($urandom);
        end else begin
            p.slice_top = ROW_W'($urandom_range(0, 511));
            p.slice_end = ROW_W'($urandom_range(p.slice_top, 511));
        end

        if ($urandom_range(0, 9) < 6 && p.slice_end > p.slice_top)
            p.row = ROW_W'($urandom_range(p.slice_top, p.slice_end - 1));
        else
            p.row = ROW_W'($urandom);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Drop valid and wait out any gap, then offer one request and hold it until
    // taken. With no gap, valid stays high and only the payload moves on.
    task automatic offer_pixel(input pixel_req_t p, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_column        <= p.column;
        s_row           <= p.row;
        s_player_x      <= p.player_x;
        s_player_y      <= p.player_y;
        s_ray_x         <= p.ray_x;
        s_ray_y         <= p.ray_y;
        s_wall_distance <= p.distance;
        s_hit_side      <= p.hit_side;
        s_slice_height  <= p.slice_height;
        s_slice_top     <= p.slice_top;
        s_slice_end     <= p.slice_end;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_random(input int count, input int gap_max);
        for (int i = 0; i < count; i++)
            offer_pixel(random_pixel(), $urandom_range(0, gap_max));
        s_valid <= 1'b0;
    endtask

    // Wait until every pixel in flight has come out, let the pipeline settle,
    // then write all three registers back to back, optionally followed by a
    // write to the unused index that the block must drop.
    task automatic write_settings(
        input logic [COLOR_W-1:0]        ceiling_c,
        input logic [COLOR_W-1:0]        floor_c,
        input logic signed [PITCH_W-1:0] pitch,
        input bit                        poke_unused
    );
        logic [CFG_IDX_W-1:0] idx [4];
        logic [COLOR_W-1:0]   val [4];
        int                   count;
        idx   = '{CFG_CEILING_COLOR, CFG_FLOOR_COLOR, CFG_VIEW_PITCH, CFG_UNUSED};
        val   = '{ceiling_c, floor_c, COLOR_W'(pitch), $urandom};
        count = poke_unused ? 4 : 3;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        for (int i = 0; i < count; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, a stall-free stretch, and one long hold
    // that backs the pipeline up while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int taken;
        int stall;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = (taken >= 500 && taken < 600) ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Abort if no channel moves for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("No handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb_raycast_column_texel_mapper: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values: black fill, view pitch 100.
        // Ceiling and floor with every other field at an extreme.
        offer_pixel(make_pixel(10'd1023, 9'd0, 24'hFFFFFF, 24'hFFFFFF, 18'sh1FFFF,
                               18'sh1FFFF, 24'hFFFFFF, 1'b1, 16'hFFFF, 9'd511, 9'd511),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd0, 9'd511, 24'h0, 24'h0, 18'sh20000, 18'sh20000,
                               24'h0, 1'b0, 16'd1, 9'd0, 9'd0), $urandom_range(0, 13));
        // East face (mirrored), west face, and west with a zero x ray.
        offer_pixel(make_pixel(10'd100, 9'd200, 24'h012345, 24'h034567, 18'sd40000,
                               18'sd12345, 24'h028000, 1'b0, 16'd300, 9'd100, 9'd400),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd101, 9'd250, 24'h0A0000, 24'h0B8000, -18'sd30000,
                               -18'sd50000, 24'h013333, 1'b0, 16'd300, 9'd100, 9'd400),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd102, 9'd150, 24'h020000, 24'h030000, 18'sd0,
                               18'sd65536, 24'h010000, 1'b0, 16'd120, 9'd140, 9'd260),
                    $urandom_range(0, 13));
        // South face, north face (mirrored), and north with a zero y ray.
        offer_pixel(make_pixel(10'd103, 9'd300, 24'h051234, 24'h069876, 18'sd22222,
                               18'sd33333, 24'h02ABCD, 1'b1, 16'd80, 9'd260, 9'd340),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd104, 9'd310, 24'h07FFFF, 24'h010001, -18'sd70000,
                               -18'sd11111, 24'h030F0F, 1'b1, 16'd500, 9'd50, 9'd450),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd105, 9'd320, 24'h00ABCD, 24'h00DCBA, -18'sd4567,
                               18'sd0, 24'h045678, 1'b1, 16'd64, 9'd300, 9'd350),
                    $urandom_range(0, 13));
        // Wall row with zero slice height.
        offer_pixel(make_pixel(10'd106, 9'd256, 24'h123456, 24'h654321, 18'sd1234,
                               -18'sd4321, 24'h00C000, 1'b0, 16'd0, 9'd200, 9'd300),
                    $urandom_range(0, 13));
        // Slice top below slice end: ceiling above the top, floor after it.
        offer_pixel(make_pixel(10'd107, 9'd200, 24'h111111, 24'h222222, 18'sd999,
                               18'sd888, 24'h033333, 1'b1, 16'd200, 9'd300, 9'd100),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd108, 9'd350, 24'h111111, 24'h222222, 18'sd999,
                               18'sd888, 24'h033333, 1'b0, 16'd200, 9'd300, 9'd100),
                    $urandom_range(0, 13));
        // Rows on either side of each slice boundary.
        offer_pixel(make_pixel(10'd200, 9'd64, 24'h030303, 24'h040404, 18'sd50000,
                               18'sd60000, 24'h018000, 1'b0, 16'd384, 9'd64, 9'd448),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd201, 9'd447, 24'h030303, 24'h040404, 18'sd50000,
                               18'sd60000, 24'h018000, 1'b1, 16'd384, 9'd64, 9'd448),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd202, 9'd448, 24'h030303, 24'h040404, 18'sd50000,
                               18'sd60000, 24'h018000, 1'b0, 16'd384, 9'd64, 9'd448),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd203, 9'd63, 24'h030303, 24'h040404, 18'sd50000,
                               18'sd60000, 24'h018000, 1'b1, 16'd384, 9'd64, 9'd448),
                    $urandom_range(0, 13));
        // Largest distance, most negative rays, tallest slice.
        offer_pixel(make_pixel(10'd511, 9'd510, 24'hFFFFFF, 24'hFFFFFF, 18'sh20000,
                               18'sh20000, 24'hFFFFFF, 1'b0, 16'hFFFF, 9'd0, 9'd511),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd512, 9'd509, 24'hFFFFFF, 24'hFFFFFF, 18'sh20000,
                               18'sh20000, 24'hFFFFFF, 1'b1, 16'hFFFF, 9'd0, 9'd511),
                    $urandom_range(0, 13));
        // Zero distance with the largest positive rays, unit slice height.
        offer_pixel(make_pixel(10'd513, 9'd300, 24'h0, 24'h0, 18'sh1FFFF, 18'sh1FFFF,
                               24'h0, 1'b0, 16'd1, 9'd299, 9'd301), $urandom_range(0, 13));
        // Top row as wall: strongly negative row offset.
        offer_pixel(make_pixel(10'd514, 9'd0, 24'h0F0F0F, 24'hF0F0F0, -18'sd1,
                               18'sd1, 24'h7FFFFF, 1'b1, 16'd2, 9'd0, 9'd1),
                    $urandom_range(0, 13));
        s_valid <= 1'b0;

        // Most negative pitch with white ceiling.
        write_settings('1, '0, 10'sh200, 1'b0);
        offer_pixel(make_pixel(10'd600, 9'd500, 24'h0ABCDE, 24'h0EDCBA, 18'sd77777,
                               -18'sd77777, 24'h05A5A5, 1'b0, 16'd1000, 9'd0, 9'd510),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd601, 9'd5, 24'h0ABCDE, 24'h0EDCBA, 18'sd77777,
                               -18'sd77777, 24'h05A5A5, 1'b1, 16'd1000, 9'd10, 9'd510),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd602, 9'd511, 24'h0ABCDE, 24'h0EDCBA, 18'sd77777,
                               -18'sd77777, 24'h05A5A5, 1'b1, 16'd1000, 9'd10, 9'd510),
                    $urandom_range(0, 13));
        s_valid <= 1'b0;

        // Most positive pitch with white floor.
        write_settings('0, '1, 10'sd511, 1'b0);
        offer_pixel(make_pixel(10'd700, 9'd0, 24'h123123, 24'h321321, -18'sd99999,
                               18'sd99999, 24'h0FEDCB, 1'b1, 16'd65535, 9'd0, 9'd200),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd701, 9'd400, 24'h123123, 24'h321321, -18'sd99999,
                               18'sd99999, 24'h0FEDCB, 1'b0, 16'd300, 9'd0, 9'd300),
                    $urandom_range(0, 13));
        offer_pixel(make_pixel(10'd702, 9'd20, 24'h123123, 24'h321321, -18'sd99999,
                               18'sd99999, 24'h0FEDCB, 1'b0, 16'd300, 9'd21, 9'd300),
                    $urandom_range(0, 13));
        s_valid <= 1'b0;

        // Random phases. The second runs without sender gaps; the long
        // result hold lands inside it and backs the pipeline up.
        write_settings($urandom, $urandom, 10'sd0, 1'b0);
        run_random(180, 13);
        write_settings('1, '0, 10'sh200, 1'b0);
        run_random(180, 0);
        write_settings($urandom, $urandom, PITCH_W'($urandom), 1'b1);
        run_random(180, 13);
        write_settings('0, '0, 10'sd100, 1'b0);
        run_random(180, 3);
        write_settings($urandom, $urandom, PITCH_W'($urandom), 1'b0);
        run_random(180, 13);

        // Drain, then give a late or extra result time to show up.
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d pixels: %0d ceiling, %0d wall, %0d floor; %0d mismatches",
                 ceiling_seen + wall_seen + floor_seen, ceiling_seen, wall_seen,
                 floor_seen, mismatch_count);
        $display("Covered %0d register settings and a %0d-cycle hold on the result side",
                 settings_applied, HOLD_CYCLES);
        if (mismatch_count == 0 && pending == 0) begin
            $display("tb_raycast_column_texel_mapper: clean");
        end else begin
            $display("tb_raycast_column_texel_mapper: errors");
        end
        $finish;
    end

endmodule : tb_raycast_column_texel_mapper

// File: raycast_column_texel_mapper.f
hdl/rcm_pkg.sv
hdl/rcm_front.sv
hdl/rcm_div_stage.sv
hdl/raycast_column_texel_mapper.sv
verif/rcm_texel_checker.sv
verif/tb_raycast_column_texel_mapper.sv
